// ===== src/signed_decimal_token_reader_macros.svh =====
// Assertion helpers shared by the token reader.
`ifndef SIGNED_DECIMAL_TOKEN_READER_MACROS_SVH
`define SIGNED_DECIMAL_TOKEN_READER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SDTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define SDTR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/sdtr_pkg.sv =====
`default_nettype none

package sdtr_pkg;

  // Default value width and the fixed width of the result number field
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned NUM_BITS       = 64;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 2;

  // Result queue depth
  localparam int unsigned FIFO_DEPTH = 4;

  // Characters of interest
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_COMMENT,
    PH_SIGN,
    PH_DIGITS
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NUMBER,
    KIND_END,
    KIND_NODELIM,
    KIND_UNEXPECTED
  } kind_e;

  // One result beat, lowest field in the lowest bits
  typedef struct packed {
    logic [7:0]          bad;
    logic [NUM_BITS-1:0] value;
    kind_e               kind;
  } result_t;

endpackage

`default_nettype wire

// ===== src/signed_decimal_token_reader.sv =====
// An accepted input beat is registered in the input stage, then its results enter the queue.
// Throughput: one input beat per cycle while the queue has room for two; an item that yields
// two results drains from the 4-entry result queue one beat per cycle while tready is high.
// Reset (rst_ni low, asynchronous): phase returns to whitespace skipping, the accumulator
// and sign clear, the input stage and the result queue empty.
`default_nettype none

module signed_decimal_token_reader #(
  parameter int unsigned VALUE_BITS = sdtr_pkg::VALUE_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // text_byte [7:0]
  input  wire  [sdtr_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // end_of_text [0]
  input  wire                                s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // number_value [63:0], bad_byte [71:64]
  output logic [sdtr_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // result_kind [1:0]
  output logic [sdtr_pkg::OUT_USER_W-1:0]    m_axis_tuser_o,
  // last_of_run
  output logic                               m_axis_tlast_o
);
  import sdtr_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  // Input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       fire;
  logic       room;

  // Scanner state
  phase_e                phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  neg_q, neg_d;

  // Result queue
  result_t          fifo_q [FIFO_DEPTH];
  logic             last_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             pop;
  result_t          head;

  // Results of the current item
  result_t    res_a, res_b;
  logic [1:0] push_n;

  // Character classes
  logic                  is_space, is_digit, is_sign, is_delim;
  logic [VALUE_BITS-1:0] digit_ext;
  logic [VALUE_BITS-1:0] acc_step;
  logic signed [VALUE_BITS-1:0] num_signed;

  // Skipping-phase handling of the current item
  phase_e  skip_phase;
  logic    skip_emit;
  result_t skip_res;

  // Checker triggers
  logic eot_fire;
  logic digit_fire;

  assign room            = count_q <= CNT_W'(FIFO_DEPTH - 2);
  assign fire            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || room;

  // Register the incoming beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eot_q  <= s_axis_tuser_i;
    end
  end

  // Classify the byte
  assign is_space = (in_byte_q == CH_SPACE) || (in_byte_q >= CH_TAB && in_byte_q <= CH_CR);
  assign is_digit = (in_byte_q >= CH_ZERO) && (in_byte_q <= CH_NINE);
  assign is_sign  = (in_byte_q == CH_MINUS) || (in_byte_q == CH_PLUS);
  assign is_delim = is_space || (in_byte_q == CH_LPAREN) || (in_byte_q == CH_RPAREN) ||
                    (in_byte_q == CH_QUOTE) || (in_byte_q == CH_SEMI);

  assign digit_ext  = VALUE_BITS'(in_byte_q[3:0] - CH_ZERO[3:0]);
  assign acc_step   = (acc_q << 3) + (acc_q << 1) + digit_ext;
  assign num_signed = neg_q ? -acc_q : acc_q;

  // Handle the item as if skipping whitespace
  always_comb begin
    skip_phase     = PH_SKIP;
    skip_emit      = 1'b0;
    skip_res.kind  = KIND_END;
    skip_res.value = '0;
    skip_res.bad   = '0;
    if (in_eot_q) begin
      skip_emit = 1'b1;
    end else if (is_space) begin
      skip_phase = PH_SKIP;
    end else if (in_byte_q == CH_SEMI) begin
      skip_phase = PH_COMMENT;
    end else if (is_digit) begin
      skip_phase = PH_DIGITS;
    end else if (is_sign) begin
      skip_phase = PH_SIGN;
    end else begin
      skip_emit     = 1'b1;
      skip_res.kind = KIND_UNEXPECTED;
      skip_res.bad  = in_byte_q;
    end
  end

  // Next scanner state
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    if (fire) begin
      case (phase_q)
        PH_COMMENT: begin
          if (in_eot_q || in_byte_q == CH_NL) begin
            phase_d = PH_SKIP;
          end
        end
        PH_SIGN: begin
          if (!in_eot_q && is_digit) begin
            acc_d   = digit_ext;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = skip_phase;
            acc_d   = is_digit ? digit_ext : '0;
            neg_d   = !in_eot_q && (in_byte_q == CH_MINUS);
          end
        end
        PH_DIGITS: begin
          if (!in_eot_q && is_digit) begin
            acc_d = acc_step;
          end else if (in_eot_q || is_delim) begin
            phase_d = skip_phase;
            acc_d   = '0;
            neg_d   = 1'b0;
          end else begin
            phase_d = PH_SKIP;
            acc_d   = '0;
            neg_d   = 1'b0;
          end
        end
        default: begin
          phase_d = skip_phase;
          acc_d   = is_digit ? digit_ext : '0;
          neg_d   = !in_eot_q && (in_byte_q == CH_MINUS);
        end
      endcase
    end
  end

  // Results of the current item
  always_comb begin
    res_a  = skip_res;
    res_b  = skip_res;
    push_n = 2'd0;
    case (phase_q)
      PH_COMMENT: begin
        if (in_eot_q) begin
          res_a.kind  = KIND_END;
          res_a.bad   = '0;
          push_n      = 2'd1;
        end
      end
      PH_SIGN: begin
        if (in_eot_q || !is_digit) begin
          res_a.kind  = KIND_UNEXPECTED;
          res_a.value = '0;
          res_a.bad   = neg_q ? CH_MINUS : CH_PLUS;
          push_n      = skip_emit ? 2'd2 : 2'd1;
        end
      end
      PH_DIGITS: begin
        if (!in_eot_q && is_digit) begin
          push_n = 2'd0;
        end else if (in_eot_q || is_delim) begin
          res_a.kind  = KIND_NUMBER;
          res_a.value = NUM_BITS'(num_signed);
          res_a.bad   = '0;
          push_n      = skip_emit ? 2'd2 : 2'd1;
        end else begin
          res_a.kind  = KIND_NODELIM;
          res_a.value = '0;
          res_a.bad   = in_byte_q;
          push_n      = 2'd1;
        end
      end
      default: begin
        push_n = skip_emit ? 2'd1 : 2'd0;
      end
    endcase
  end

  // Scanner state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      acc_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk_i) begin
    if (fire && push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res_a;
      last_q[wr_ptr_q] <= (push_n == 2'd1);
      if (push_n == 2'd2) begin
        fifo_q[wr_ptr_q + PTR_W'(1)] <= res_b;
        last_q[wr_ptr_q + PTR_W'(1)] <= 1'b1;
      end
    end
  end

  // Advance queue pointers and fill count
  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + (fire ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  // Drive the head beat
  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid_o = count_q != '0;
  assign m_axis_tdata_o  = {head.bad, head.value};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = last_q[rd_ptr_q];

  assign eot_fire   = fire && in_eot_q;
  assign digit_fire = fire && !in_eot_q && is_digit && (phase_q != PH_COMMENT);

`include "signed_decimal_token_reader_macros.svh"

  `SDTR_ASSERT(a_count_bound, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `SDTR_ASSERT_NEXT(a_eot_skip, eot_fire, phase_q == PH_SKIP, "end mark left a token open")
  `SDTR_ASSERT_NEXT(a_digit_enters, digit_fire, phase_q == PH_DIGITS, "digit missed number")

endmodule

`default_nettype wire
